// File: src/serial_line_assembler_defines.svh
// ----------------------------------------------------------------------------
// serial_line_assembler_defines.svh
// Assertion macros for the checker of the serial line assembler.
// ----------------------------------------------------------------------------
`ifndef SERIAL_LINE_ASSEMBLER_DEFINES_SVH
`define SERIAL_LINE_ASSEMBLER_DEFINES_SVH

// Same-cycle implication, clocked on clk and disabled during rst.
`define SLA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk and disabled during rst.
`define SLA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/sla_pkg.sv
// ----------------------------------------------------------------------------
// sla_pkg
// Constants and helpers shared by the serial line assembler files.
// ----------------------------------------------------------------------------
`default_nettype none

package sla_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_CHAR     = 2'd0;
  localparam logic [1:0] KIND_EMPTY    = 2'd1;
  localparam logic [1:0] KIND_OVERFLOW = 2'd2;

  // Special characters.
  localparam logic [7:0] CHAR_CR  = 8'd13;
  localparam logic [7:0] CHAR_LF  = 8'd10;
  localparam logic [7:0] CHAR_SP  = 8'd32;
  localparam logic [7:0] CHAR_TAB = 8'd9;

  // Configuration register indexes and port widths.
  localparam int          CFG_IDX_W   = 2;
  localparam int          CFG_DATA_W  = 7;
  localparam logic [1:0]  REG_MAX_LEN = 2'd0;
  localparam logic [1:0]  REG_TRIM    = 2'd1;
  localparam logic [1:0]  REG_EMPTY   = 2'd2;

  typedef logic [1:0] kind_t;

  // True for a space or a tab.
  function automatic logic is_blank(input logic [7:0] c);
    return (c == CHAR_SP) || (c == CHAR_TAB);
  endfunction

endpackage

`default_nettype wire

// File: src/serial_line_assembler.sv
// ----------------------------------------------------------------------------
// serial_line_assembler
// Builds text lines from received bytes and emits them one character per item.
// ----------------------------------------------------------------------------
// While a line is being assembled the block takes one byte per clock cycle:
// each byte kept for the line is written into the line RAM in the cycle it is
// accepted, and the first and last non-blank positions are tracked on the fly,
// so trimming needs no pass of its own. A line feed that ends a non-empty line
// starts a readout in which each emitted character goes through a registered
// RAM read and then the output register, and waits while the output is stalled;
// no input byte is taken during the readout. Overflow errors and empty line
// markers go straight into the output register, and a new byte is taken while
// such a result waits unless the output side is stalling. The line RAM needs
// no clearing after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_line_assembler #(
  parameter int LINE_DEPTH = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // Configuration write port.
  input  wire logic                             cfg_en,
  input  wire logic [sla_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sla_pkg::CFG_DATA_W-1:0]   cfg_data,
  // Input channel.
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [7:0]                       rx_byte,
  // Output channel.
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output sla_pkg::kind_t                        kind,
  output logic [7:0]                            data_byte,
  output logic                                  last
);

  localparam int         AW        = $clog2(LINE_DEPTH);
  localparam int         CW        = $clog2(LINE_DEPTH + 1);
  localparam logic [6:0] DEPTH_LIM = 7'(LINE_DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  // Configuration registers.
  logic [6:0] max_line_length;
  logic       trim_enable;
  logic       empty_enable;

  // Line state.
  logic          state;
  logic [CW-1:0] count;
  logic          discard;
  logic          have_nb;
  logic [AW-1:0] first_nb;
  logic [AW-1:0] last_nb;

  // Readout state.
  logic [AW-1:0] rd_ptr;
  logic [AW-1:0] rd_end;
  logic          pend;
  logic          pend_last;

  // Combinational control.
  logic          accept;
  logic          out_free;
  logic [6:0]    limit;
  logic          room;
  logic          is_cr;
  logic          is_lf;
  logic          store;
  logic          ovf;
  logic          lf_line;
  logic          lf_discard;
  logic          line_empty;
  logic [AW-1:0] line_first;
  logic [AW-1:0] line_last;
  logic          issue;
  logic          ld_empty;
  logic [7:0]    rd_data;

  // Handshake and classification of the incoming byte.
  always_comb begin
    in_stall   = (state == ST_READ) || (out_valid && out_stall);
    accept     = in_valid && !in_stall;
    out_free   = !out_valid || !out_stall;
    limit      = (max_line_length > DEPTH_LIM) ? DEPTH_LIM : max_line_length;
    room       = 7'(count) < limit;
    is_cr      = rx_byte == sla_pkg::CHAR_CR;
    is_lf      = rx_byte == sla_pkg::CHAR_LF;
    store      = accept && !is_cr && !is_lf && !discard && room;
    ovf        = accept && !is_cr && !is_lf && !discard && !room;
    lf_line    = accept && is_lf && !discard;
    lf_discard = accept && is_lf && discard;
  end

  // Range of the line to emit, trimmed or whole.
  always_comb begin
    if (trim_enable) begin
      line_empty = !have_nb;
      line_first = first_nb;
      line_last  = last_nb;
    end else begin
      line_empty = count == '0;
      line_first = '0;
      line_last  = AW'(count - CW'(1));
    end
    ld_empty = lf_line && line_empty && empty_enable;
    issue    = (state == ST_READ) && !pend && out_free;
  end

  // Line store.
  sla_ram #(
    .WIDTH (8),
    .DEPTH (LINE_DEPTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (store),
    .wr_addr (count[AW-1:0]),
    .wr_data (rx_byte),
    .rd_en   (issue),
    .rd_addr (rd_ptr),
    .rd_data (rd_data)
  );

  // Control state, configuration and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_line_length <= 7'd64;
      trim_enable     <= 1'b1;
      empty_enable    <= 1'b0;
      state           <= ST_IDLE;
      count           <= '0;
      discard         <= 1'b0;
      have_nb         <= 1'b0;
      pend            <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      // Configuration writes; indexes beyond the list are ignored.
      if (cfg_en) begin
        case (cfg_index)
          sla_pkg::REG_MAX_LEN: max_line_length <= cfg_data;
          sla_pkg::REG_TRIM:    trim_enable     <= cfg_data[0];
          sla_pkg::REG_EMPTY:   empty_enable    <= cfg_data[0];
          default: ;
        endcase
      end

      // Assembling the line.
      if (store) begin
        count <= count + CW'(1);
        if (!sla_pkg::is_blank(rx_byte)) begin
          have_nb <= 1'b1;
        end
      end
      if (ovf || lf_line || lf_discard) begin
        count   <= '0;
        have_nb <= 1'b0;
      end
      if (ovf) begin
        discard <= 1'b1;
      end
      if (lf_discard) begin
        discard <= 1'b0;
      end
      if (lf_line && !line_empty) begin
        state <= ST_READ;
      end

      // Readout sequencing.
      if (issue) begin
        pend <= 1'b1;
      end
      if (pend) begin
        pend <= 1'b0;
        if (pend_last) begin
          state <= ST_IDLE;
        end
      end

      // Output register valid.
      if (ovf || ld_empty || pend) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: line positions, read pointers and output fields.
  always_ff @(posedge clk) begin
    if (store && !sla_pkg::is_blank(rx_byte)) begin
      if (!have_nb) begin
        first_nb <= count[AW-1:0];
      end
      last_nb <= count[AW-1:0];
    end
    if (lf_line && !line_empty) begin
      rd_ptr <= line_first;
      rd_end <= line_last;
    end
    if (issue) begin
      rd_ptr    <= rd_ptr + AW'(1);
      pend_last <= rd_ptr == rd_end;
    end
    if (ovf) begin
      kind      <= sla_pkg::KIND_OVERFLOW;
      data_byte <= 8'd0;
      last      <= 1'b1;
    end else if (ld_empty) begin
      kind      <= sla_pkg::KIND_EMPTY;
      data_byte <= 8'd0;
      last      <= 1'b1;
    end else if (pend) begin
      kind      <= sla_pkg::KIND_CHAR;
      data_byte <= rd_data;
      last      <= pend_last;
    end
  end

endmodule

`default_nettype wire

// File: src/sla_ram.sv
// ----------------------------------------------------------------------------
// sla_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: src/sla_checker.sv
// ----------------------------------------------------------------------------
// sla_checker
// Port-level checks of the serial line assembler, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "serial_line_assembler_defines.svh"

module sla_checker (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_stall,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic [1:0]           kind,
  input wire logic [7:0]           data_byte,
  input wire logic                 last
);

  // Shorthands for the output side.
  logic        blocked;
  logic        marker;
  logic [10:0] payload;

  assign blocked = out_valid && out_stall;
  assign marker  = out_valid && (kind != sla_pkg::KIND_CHAR);
  assign payload = {kind, data_byte, last};

  // A stalled result keeps its payload.
  `SLA_ASSERT_NEXT(a_out_hold, blocked, out_valid && $stable(payload), "stalled item changed")

  // Markers and errors are single results with no data.
  `SLA_ASSERT_NOW(a_single_result, marker, last && data_byte == 8'd0, "marker malformed")

  // No byte is taken while a result is held back by a stall.
  `SLA_ASSERT_NOW(a_no_accept_blocked, blocked, in_stall, "input taken while output blocked")

  // Right after reset nothing is shown on the output.
  `SLA_ASSERT_NOW(a_reset_quiet, $past(rst), !out_valid, "result shown right after reset")

endmodule

bind serial_line_assembler sla_checker u_sla_checker (.*);

`default_nettype wire

// File: test/serial_line_assembler_tb.sv
// ----------------------------------------------------------------------------
// serial_line_assembler_tb
// Self-checking testbench for the serial line assembler.
// ----------------------------------------------------------------------------
// A short scripted sequence covers trimming, empty lines, overflow and the
// discard that follows it, zero and all-ones bytes, carriage returns and the
// length limits at zero, at two and above the line depth. Random lines then run
// under several register settings, one setting with a full-depth line and a long
// output hold. A line model in the bench predicts the results, and each accepted
// result is checked against it field by field in order, except for scripted rows
// whose result is written into the script.
// ----------------------------------------------------------------------------
module serial_line_assembler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_DEPTH    = 64;
  localparam int MAX_GAP       = 12;
  // Quiet time that settle() allows after the last expected result.
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 400;
  localparam int PHASE_ITEMS   = 6;
  localparam int NUM_PHASES    = 6;
  localparam int CYCLE_LIMIT   = 200000;

  typedef struct packed {
    sla_pkg::kind_t kind;
    logic [7:0]     data_byte;
    logic           last;
  } line_result_t;

  typedef enum logic {OP_WRITE_REG, OP_RX} row_op_t;
  typedef enum logic [1:0] {BY_MODEL, NO_RESULT, EMPTY_MARK, OVERFLOW_ERR} check_t;

  typedef struct packed {
    row_op_t                        op;
    logic [sla_pkg::CFG_IDX_W-1:0]  reg_idx;
    logic [7:0]                     value;
    check_t                         check;
  } script_row_t;

  logic                           clk;
  logic                           rst;
  logic                           cfg_en;
  logic [sla_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [sla_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                           in_valid;
  logic                           in_stall;
  logic [7:0]                     rx_byte;
  logic                           out_valid;
  logic                           out_stall;
  sla_pkg::kind_t                 kind;
  logic [7:0]                     data_byte;
  logic                           last;

  // Line model state and its copy of the registers.
  logic [7:0]  line_buf [LINE_DEPTH];
  int unsigned line_len;
  bit          dropping;
  logic [6:0]  max_len_reg;
  bit          trim_reg;
  bit          empty_reg;

  line_result_t step_results[$];
  line_result_t pending_results[$];
  script_row_t  script[$];

  int error_count;
  int rx_items;
  int cycle_count;
  int rx_hold_cycles;
  int rx_wait;
  bit tx_calm;
  bit rx_calm;

  serial_line_assembler #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_en(cfg_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind(kind),
    .data_byte(data_byte),
    .last(last)
  );

  // Advances the line model by one byte and leaves its results in step_results.
  function automatic void assemble_byte(input logic [7:0] c);
    int unsigned limit;
    int unsigned first;
    int unsigned stop;
    step_results.delete();
    limit = (max_len_reg > LINE_DEPTH) ? LINE_DEPTH : max_len_reg;
    if (c == sla_pkg::CHAR_CR) return;
    if (c == sla_pkg::CHAR_LF) begin
      if (dropping) begin
        dropping = 1'b0;
        line_len = 0;
        return;
      end
      first = 0;
      stop  = line_len;
      if (trim_reg) begin
        while (first < stop && sla_pkg::is_blank(line_buf[first]))
          first++;
        while (stop > first && sla_pkg::is_blank(line_buf[stop-1]))
          stop--;
      end
      if (stop > first) begin
        for (int unsigned i = first; i < stop; i++)
          step_results.push_back(
            line_result_t'{sla_pkg::KIND_CHAR, line_buf[i], (i + 1 == stop)});
      end else if (empty_reg) begin
        step_results.push_back(line_result_t'{sla_pkg::KIND_EMPTY, 8'd0, 1'b1});
      end
      line_len = 0;
      return;
    end
    if (dropping) return;
    if (line_len < limit) begin
      line_buf[line_len] = c;
      line_len++;
      return;
    end
    // The byte does not fit: report it once and drop the rest of the line.
    step_results.push_back(line_result_t'{sla_pkg::KIND_OVERFLOW, 8'd0, 1'b1});
    line_len = 0;
    dropping = 1'b1;
  endfunction

  // Line content: mostly printable text and blanks; plain lines carry nothing else.
  function automatic logic [7:0] random_char(input bit plain);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) return ($urandom_range(0, 1) != 0) ? sla_pkg::CHAR_SP : sla_pkg::CHAR_TAB;
    if (pick == 2 && !plain) return sla_pkg::CHAR_CR;
    if (pick == 3 && !plain) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(33, 126));
  endfunction

  function automatic script_row_t reg_row(input logic [sla_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [7:0] val);
    return script_row_t'{OP_WRITE_REG, idx, val, NO_RESULT};
  endfunction

  function automatic script_row_t rx_row(input logic [7:0] b, input check_t how);
    return script_row_t'{OP_RX, '0, b, how};
  endfunction

  // Writes one register; the block is idle whenever this is called.
  task automatic write_reg(input logic [sla_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sla_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_en    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_en <= 1'b0;
    case (idx)
      sla_pkg::REG_MAX_LEN: max_len_reg = val;
      sla_pkg::REG_TRIM:    trim_reg    = val[0];
      sla_pkg::REG_EMPTY:   empty_reg   = val[0];
      default: ;
    endcase
  endtask

  // Offers one byte after a random gap and returns at the edge that takes it.
  task automatic send_byte(input logic [7:0] b, input check_t how);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    if (b != sla_pkg::CHAR_CR) rx_items++;
    assemble_byte(b);
    case (how)
      BY_MODEL:     foreach (step_results[i]) pending_results.push_back(step_results[i]);
      EMPTY_MARK:   pending_results.push_back(line_result_t'{sla_pkg::KIND_EMPTY, 8'd0, 1'b1});
      OVERFLOW_ERR:
        pending_results.push_back(line_result_t'{sla_pkg::KIND_OVERFLOW, 8'd0, 1'b1});
      default: ;
    endcase
  endtask

  task automatic send_line(input int len, input bit plain);
    for (int i = 0; i < len; i++) send_byte(random_char(plain), BY_MODEL);
    send_byte(sla_pkg::CHAR_LF, BY_MODEL);
  endtask

  // Stops offering, waits for every expected result, then lets the block go quiet.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("serial_line_assembler test failed");
      $finish;
    end
  end

  // Output side: a random stall after each item, plus the long hold when asked.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        out_stall <= 1'b1;
        rx_hold_cycles--;
      end else if (rx_wait > 0) begin
        out_stall <= 1'b1;
        rx_wait--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Compares each accepted result with the oldest expected one.
  always @(posedge clk) begin
    line_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d data_byte 0x%02h last %0d", kind, data_byte, last);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind);
          error_count++;
        end
        if (data_byte !== want.data_byte) begin
          $error("data_byte: expected 0x%02h, got 0x%02h", want.data_byte, data_byte);
          error_count++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last);
          error_count++;
        end
      end
      rx_wait = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
    end
  end

  initial begin
    logic [6:0] new_max;
    int         lim;
    int         first_item;
    rst         = 1'b1;
    cfg_en      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    rx_byte     = '0;
    max_len_reg = 7'd64;
    trim_reg    = 1'b1;
    empty_reg   = 1'b0;
    line_len    = 0;
    dropping    = 1'b0;
    tx_calm     = 1'b0;
    rx_calm     = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: an empty line is silent, blanks are trimmed around 0xff and 0x00.
    script.push_back(rx_row(sla_pkg::CHAR_LF, NO_RESULT));
    script.push_back(rx_row(sla_pkg::CHAR_CR, NO_RESULT));
    script.push_back(rx_row(sla_pkg::CHAR_SP, BY_MODEL));
    script.push_back(rx_row(8'hff, BY_MODEL));
    script.push_back(rx_row(8'h00, BY_MODEL));
    script.push_back(rx_row(sla_pkg::CHAR_TAB, BY_MODEL));
    script.push_back(rx_row(sla_pkg::CHAR_LF, BY_MODEL));
    // No trimming and empty line markers on.
    script.push_back(reg_row(sla_pkg::REG_TRIM, 8'd0));
    script.push_back(reg_row(sla_pkg::REG_EMPTY, 8'd1));
    script.push_back(rx_row(sla_pkg::CHAR_SP, BY_MODEL));
    script.push_back(rx_row(sla_pkg::CHAR_LF, BY_MODEL));
    script.push_back(rx_row(sla_pkg::CHAR_LF, EMPTY_MARK));
    // A line of blanks only is empty once trimmed.
    script.push_back(reg_row(sla_pkg::REG_TRIM, 8'd1));
    script.push_back(rx_row(sla_pkg::CHAR_TAB, NO_RESULT));
    script.push_back(rx_row(sla_pkg::CHAR_SP, NO_RESULT));
    script.push_back(rx_row(sla_pkg::CHAR_LF, EMPTY_MARK));
    // A zero limit overflows on the first byte, the rest of the line is dropped.
    script.push_back(reg_row(sla_pkg::REG_MAX_LEN, 8'd0));
    script.push_back(rx_row(8'h78, OVERFLOW_ERR));
    script.push_back(rx_row(8'h79, NO_RESULT));
    script.push_back(rx_row(sla_pkg::CHAR_CR, NO_RESULT));
    script.push_back(rx_row(sla_pkg::CHAR_LF, NO_RESULT));
    // Overflow on the third byte with a limit of two.
    script.push_back(reg_row(sla_pkg::REG_MAX_LEN, 8'd2));
    script.push_back(rx_row(8'h61, NO_RESULT));
    script.push_back(rx_row(8'h62, NO_RESULT));
    script.push_back(rx_row(8'h63, OVERFLOW_ERR));
    script.push_back(rx_row(sla_pkg::CHAR_LF, NO_RESULT));
    // A limit above the line depth; an inner tab is kept.
    script.push_back(reg_row(sla_pkg::REG_MAX_LEN, 8'd127));
    script.push_back(rx_row(8'h61, BY_MODEL));
    script.push_back(rx_row(sla_pkg::CHAR_TAB, BY_MODEL));
    script.push_back(rx_row(8'h62, BY_MODEL));
    script.push_back(rx_row(sla_pkg::CHAR_LF, BY_MODEL));

    foreach (script[i]) begin
      if (script[i].op == OP_WRITE_REG) begin
        settle();
        write_reg(script[i].reg_idx, script[i].value[sla_pkg::CFG_DATA_W-1:0]);
      end else begin
        send_byte(script[i].value, script[i].check);
      end
    end

    // Random lines, one register setting per phase.
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      case (p)
        0:       new_max = 7'd127;
        1:       new_max = 7'd64;
        2:       new_max = 7'd1;
        default: new_max = 7'($urandom_range(0, 20));
      endcase
      write_reg(sla_pkg::REG_MAX_LEN, new_max);
      write_reg(sla_pkg::REG_TRIM, (p == 0) ? 7'd0 : 7'($urandom_range(0, 1)));
      write_reg(sla_pkg::REG_EMPTY, (p == 1) ? 7'd1 : 7'($urandom_range(0, 1)));
      rx_calm = ($urandom_range(0, 3) == 0);
      if (p == 0) begin
        // Full-depth line with the output held off, so the readout backs up
        // into the input while the next line is offered.
        tx_calm = 1'b1;
        @(posedge clk);
        rx_hold_cycles = LONG_HOLD;
        send_line(LINE_DEPTH, 1'b1);
        send_line(3, 1'b1);
      end else begin
        tx_calm    = ($urandom_range(0, 3) == 0);
        lim        = (new_max > 10) ? 10 : new_max;
        first_item = rx_items;
        while (rx_items - first_item < PHASE_ITEMS)
          send_line($urandom_range(0, lim + 2), ($urandom_range(0, 3) == 0));
      end
    end

    settle();
    if (error_count == 0) begin
      $display("serial_line_assembler test passed");
    end else begin
      $display("serial_line_assembler test failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/sla_pkg.sv
src/sla_ram.sv
src/serial_line_assembler.sv
src/sla_checker.sv
test/serial_line_assembler_tb.sv
